@@ rtl/rhmf_pkg.sv @@
// Shared types and constants for the running histogram median filter.
// No dependencies; every other file in rtl/ but the line store imports this package.
`timescale 1ns / 1ps
package rhmf_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HALF  = 7;
	localparam int GREY_LEVELS   = 256;
	localparam int QUEUE_DEPTH   = 2;

	// Widest column and line-store slot that any parameter setting needs.
	localparam int JOB_COL_W  = 12;
	localparam int JOB_SLOT_W = 5;

	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [11:0] RST_HEIGHT = 12'd480;
	localparam logic [2:0]  RST_HALF   = 3'd1;

	typedef enum logic [1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_HALF_COLS,
		REG_HALF_ROWS
	} reg_idx_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FILL,
		BK_DRAIN,
		BK_SCAN,
		BK_EMIT
	} bk_state_t;

	// One median job, handed from the front to the back.
	typedef struct packed {
		logic [JOB_SLOT_W-1:0] slot;
		logic [JOB_COL_W-1:0]  col;
		logic [11:0]           row;
		logic [2:0]            hc;
		logic [2:0]            hr;
		logic                  last;
	} job_t;

	typedef struct packed {
		logic [QUEUE_DEPTH-1:0]                 vld;
		logic [QUEUE_DEPTH-1:0][JOB_SLOT_W-1:0] slot;
	} q_status_t;

	typedef struct packed {
		logic                  busy;
		logic [JOB_SLOT_W-1:0] slot;
	} bk_status_t;

endpackage

@@ rtl/running_histogram_median_filter_top.sv @@
// Top level of the running histogram median filter: front, job queue,
// line store and back. Depends on rhmf_pkg and the rhmf_* modules.
`timescale 1ns / 1ps
// Pixels enter in raster order, one per clock, as long as the two-entry job
// queue has room and the incoming row does not reuse a line-store row that a
// pending window still reads. Every pixel whose window lies fully inside the
// image creates a median job. The back end handles one job at a time: it
// reads the window from the line store at one pixel per clock through the
// RAM's single read port, builds a 256-bin histogram, then scans the bins
// from grey level zero until the count passes half the window. The
// histogram's valid bits are all cleared at the start of each job; there is
// no clearing pass after reset. A configuration write restarts the frame at
// column and row zero and must only be issued while no transaction is
// outstanding.
module running_histogram_median_filter_top
	import rhmf_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HALF  = DEF_MAX_HALF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  logic [7:0]  pixel,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  median,
	output logic [9:0]  out_col,
	output logic [11:0] out_row,
	output logic        frame_last
);
	// Column bits and line-store slot bits; the slot count is a power of two
	// with at least one row more than the tallest window.
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int SLOT_W = $clog2(2 * MAX_HALF + 2);
	localparam int LS_AW  = SLOT_W + CW;

	logic             ls_we;
	logic [LS_AW-1:0] ls_waddr;
	logic [7:0]       ls_wdata;
	logic             ls_re;
	logic [LS_AW-1:0] ls_raddr;
	logic [7:0]       ls_rdata;
	logic             push;
	job_t             push_job;
	logic             q_full;
	q_status_t        q_st;
	logic             pop;
	logic             head_vld;
	job_t             head_job;
	bk_status_t       bk_st;

	// Register writes complete in the access phase without wait states.
	assign pready = 1'b1;

	rhmf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HALF  (MAX_HALF),
		.CW        (CW),
		.SLOT_W    (SLOT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.ls_we       (ls_we),
		.ls_waddr    (ls_waddr),
		.ls_wdata    (ls_wdata),
		.push        (push),
		.push_job    (push_job),
		.q_full      (q_full),
		.q_st        (q_st),
		.bk_st       (bk_st)
	);

	rhmf_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head_vld (head_vld),
		.head_job (head_job),
		.status   (q_st)
	);

	rhmf_line_store #(
		.AW (LS_AW)
	) u_line_store (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (ls_wdata),
		.re    (ls_re),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	rhmf_back #(
		.CW     (CW),
		.SLOT_W (SLOT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_vld     (head_vld),
		.head_job     (head_job),
		.pop          (pop),
		.ls_re        (ls_re),
		.ls_raddr     (ls_raddr),
		.ls_rdata     (ls_rdata),
		.bk_st        (bk_st),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.median       (median),
		.out_col      (out_col),
		.out_row      (out_row),
		.frame_last   (frame_last)
	);
endmodule

@@ rtl/rhmf_line_store.sv @@
// Line store RAM: one write port, one read port with registered data.
// Uses no package.
`timescale 1ns / 1ps
module rhmf_line_store #(
	parameter int AW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [2**AW];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/rhmf_job_queue.sv @@
// Two-entry job queue between the front and the back.
// Depends on rhmf_pkg for job_t and q_status_t.
`timescale 1ns / 1ps
module rhmf_job_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rhmf_pkg::job_t     push_job,
	output logic               full,
	input  logic               pop,
	output logic               head_vld,
	output rhmf_pkg::job_t     head_job,
	output rhmf_pkg::q_status_t status
);
	import rhmf_pkg::*;

	job_t       ent_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign head_vld = (cnt_q != 2'd0);
	assign head_job = ent_q[rd_ptr_q];

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			status.vld[i]  = (cnt_q == 2'd2) || ((cnt_q == 2'd1) && (rd_ptr_q == 1'(i)));
			status.slot[i] = ent_q[i].slot;
		end
	end
endmodule

@@ rtl/rhmf_front.sv @@
// Front end: configuration registers, raster position, line-store writes and
// job classification. Depends on rhmf_pkg.
`timescale 1ns / 1ps
module rhmf_front #(
	parameter int MAX_WIDTH = rhmf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HALF  = rhmf_pkg::DEF_MAX_HALF,
	parameter int CW        = $clog2(MAX_WIDTH),
	parameter int SLOT_W    = $clog2(2 * MAX_HALF + 2)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	input  logic                    pixel_valid,
	output logic                    pixel_stall,
	input  logic [7:0]              pixel,
	output logic                    ls_we,
	output logic [SLOT_W+CW-1:0]    ls_waddr,
	output logic [7:0]              ls_wdata,
	output logic                    push,
	output rhmf_pkg::job_t          push_job,
	input  logic                    q_full,
	input  rhmf_pkg::q_status_t     q_st,
	input  rhmf_pkg::bk_status_t    bk_st
);
	import rhmf_pkg::*;

	logic [10:0]       width_q;
	logic [11:0]       height_q;
	logic [2:0]        hc_q;
	logic [2:0]        hr_q;
	logic [CW-1:0]     col_q;
	logic [11:0]       row_q;
	logic [SLOT_W-1:0] slot_q;

	logic [12:0] w_eff;
	logic [10:0] w_nz;
	logic [11:0] h_eff;
	logic [2:0]  hc_eff;
	logic [2:0]  hr_eff;
	logic        cfg_wr;
	logic        accept;
	logic        hazard;
	logic        produce;
	logic        col_end;
	logic        row_end;

	function automatic logic too_far(input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b);
		logic [SLOT_W-1:0] d;
		d = a - b;
		return d > SLOT_W'(1);
	endfunction

	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_WIDTH:     prdata = {21'd0, width_q};
			REG_HEIGHT:    prdata = {20'd0, height_q};
			REG_HALF_COLS: prdata = {29'd0, hc_q};
			REG_HALF_ROWS: prdata = {29'd0, hr_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign w_nz   = (width_q == 11'd0) ? 11'd1 : width_q;
	assign w_eff  = (13'(w_nz) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(w_nz);
	assign h_eff  = (height_q == 12'd0) ? 12'd1 : height_q;
	assign hc_eff = (int'(hc_q) > MAX_HALF) ? 3'(MAX_HALF) : hc_q;
	assign hr_eff = (int'(hr_q) > MAX_HALF) ? 3'(MAX_HALF) : hr_q;

	assign col_end = (13'(col_q) + 13'd1) >= w_eff;
	assign row_end = (13'(row_q) + 13'd1) >= 13'(h_eff);
	assign produce = (13'(col_q) >= 13'({hc_eff, 1'b0})) && (row_q >= 12'({hr_eff, 1'b0}));

	// A new pixel may not land in a line-store slot that a pending window reads.
	always_comb begin
		hazard = bk_st.busy && too_far(slot_q, bk_st.slot[SLOT_W-1:0]);
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (q_st.vld[i] && too_far(slot_q, q_st.slot[i][SLOT_W-1:0])) begin
				hazard = 1'b1;
			end
		end
	end

	assign pixel_stall = q_full || hazard;
	assign accept      = pixel_valid && !pixel_stall;

	assign ls_we    = accept;
	assign ls_waddr = {slot_q, col_q};
	assign ls_wdata = pixel;

	assign push          = accept && produce;
	assign push_job.slot = JOB_SLOT_W'(slot_q);
	assign push_job.col  = JOB_COL_W'(col_q);
	assign push_job.row  = row_q;
	assign push_job.hc   = hc_eff;
	assign push_job.hr   = hr_eff;
	assign push_job.last = col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			hc_q     <= RST_HALF;
			hr_q     <= RST_HALF;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_WIDTH:     width_q  <= pwdata[10:0];
				REG_HEIGHT:    height_q <= pwdata[11:0];
				REG_HALF_COLS: hc_q     <= pwdata[2:0];
				REG_HALF_ROWS: hr_q     <= pwdata[2:0];
				default:       width_q  <= width_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q  <= '0;
				row_q  <= row_end ? 12'd0 : row_q + 12'd1;
				slot_q <= slot_q + SLOT_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end
endmodule

@@ rtl/rhmf_back.sv @@
// Back end: builds the window histogram from the line store, scans it for
// the median and holds the result register. Depends on rhmf_pkg.
`timescale 1ns / 1ps
module rhmf_back #(
	parameter int CW     = 10,
	parameter int SLOT_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_vld,
	input  rhmf_pkg::job_t        head_job,
	output logic                  pop,
	output logic                  ls_re,
	output logic [SLOT_W+CW-1:0]  ls_raddr,
	input  logic [7:0]            ls_rdata,
	output rhmf_pkg::bk_status_t  bk_st,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            median,
	output logic [9:0]            out_col,
	output logic [11:0]           out_row,
	output logic                  frame_last
);
	import rhmf_pkg::*;

	bk_state_t state_q, state_nxt;

	job_t              job_q;
	logic [7:0]        wsize_q;
	logic [SLOT_W-1:0] rowp_q;
	logic [CW-1:0]     colp_q;
	logic [CW-1:0]     col_start_q;
	logic [7:0]        g_q;
	logic [7:0]        cum_q;
	logic [7:0]        med_q;
	logic [GREY_LEVELS-1:0] hv_q;
	logic [7:0]        hist_mem [GREY_LEVELS];
	logic [7:0]        hist_rdata_q;
	logic              vld_s2;
	logic              vld_s3;
	logic [7:0]        bin_s3;
	logic              sv_s2;
	logic [7:0]        g_s2;
	logic              fw_vld_q;
	logic [7:0]        fw_bin_q;
	logic [7:0]        fw_val_q;
	logic              res_vld_q;
	logic [7:0]        res_med_q;
	logic [9:0]        res_col_q;
	logic [11:0]       res_row_q;
	logic              res_last_q;

	logic        fill_last;
	logic        drained;
	logic        scan_issue;
	logic        emit;
	logic [7:0]  hist_raddr;
	logic [7:0]  base_cnt;
	logic [7:0]  new_cnt;
	logic [7:0]  scan_cnt;
	logic [8:0]  cum_sum;
	logic        found;

	assign fill_last = (rowp_q == job_q.slot[SLOT_W-1:0]) && (colp_q == job_q.col[CW-1:0]);
	assign drained   = !vld_s2 && !vld_s3;
	assign scan_cnt  = hv_q[g_s2] ? hist_rdata_q : 8'd0;
	assign cum_sum   = {1'b0, cum_q} + {1'b0, scan_cnt};
	assign found     = sv_s2 && ({cum_sum, 1'b0} > {2'b00, wsize_q});

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE:  if (head_vld) state_nxt = BK_FILL;
			BK_FILL:  if (fill_last) state_nxt = BK_DRAIN;
			BK_DRAIN: if (drained) state_nxt = BK_SCAN;
			BK_SCAN:  if (found) state_nxt = BK_EMIT;
			BK_EMIT:  if (!res_vld_q || !result_stall) state_nxt = BK_IDLE;
			default:  state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		ls_re      = 1'b0;
		scan_issue = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			BK_IDLE:  pop = head_vld;
			BK_FILL:  ls_re = 1'b1;
			BK_DRAIN: ;
			BK_SCAN:  scan_issue = !found;
			BK_EMIT:  emit = !res_vld_q || !result_stall;
			default:  ;
		endcase
	end

	assign ls_raddr   = {rowp_q, colp_q};
	assign bk_st.busy = (state_q != BK_IDLE);
	assign bk_st.slot = job_q.slot;

	// The bin written by the previous update is not yet visible on the read port.
	assign base_cnt = (fw_vld_q && (fw_bin_q == bin_s3)) ? fw_val_q :
	                  (hv_q[bin_s3] ? hist_rdata_q : 8'd0);
	assign new_cnt  = base_cnt + 8'd1;
	assign hist_raddr = (state_q == BK_SCAN) ? g_q : ls_rdata;

	always_ff @(posedge clk) begin
		hist_rdata_q <= hist_mem[hist_raddr];
		if (vld_s3) begin
			hist_mem[bin_s3] <= new_cnt;
		end
	end

	always_ff @(posedge clk) begin
		bin_s3   <= ls_rdata;
		g_s2     <= g_q;
		fw_bin_q <= bin_s3;
		fw_val_q <= new_cnt;
		if (pop) begin
			job_q       <= head_job;
			wsize_q     <= 8'({head_job.hc, 1'b1}) * 8'({head_job.hr, 1'b1});
			rowp_q      <= head_job.slot[SLOT_W-1:0] - SLOT_W'({head_job.hr, 1'b0});
			colp_q      <= head_job.col[CW-1:0] - CW'({head_job.hc, 1'b0});
			col_start_q <= head_job.col[CW-1:0] - CW'({head_job.hc, 1'b0});
		end else if (ls_re) begin
			if (colp_q == job_q.col[CW-1:0]) begin
				colp_q <= col_start_q;
				rowp_q <= rowp_q + SLOT_W'(1);
			end else begin
				colp_q <= colp_q + CW'(1);
			end
		end
		if (found) begin
			med_q <= g_s2;
		end
		if (emit) begin
			res_med_q  <= med_q;
			res_col_q  <= 10'(job_q.col - JOB_COL_W'(job_q.hc));
			res_row_q  <= job_q.row - 12'(job_q.hr);
			res_last_q <= job_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			sv_s2     <= 1'b0;
			fw_vld_q  <= 1'b0;
			hv_q      <= '0;
			g_q       <= '0;
			cum_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			vld_s2   <= ls_re;
			vld_s3   <= vld_s2;
			sv_s2    <= scan_issue;
			fw_vld_q <= vld_s3 && !pop;
			if (pop) begin
				hv_q  <= '0;
				g_q   <= '0;
				cum_q <= '0;
			end else begin
				if (vld_s3) begin
					hv_q[bin_s3] <= 1'b1;
				end
				if (scan_issue && (g_q != 8'hFF)) begin
					g_q <= g_q + 8'd1;
				end
				if (sv_s2) begin
					cum_q <= cum_sum[7:0];
				end
			end
			if (emit) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_vld_q;
	assign median       = res_med_q;
	assign out_col      = res_col_q;
	assign out_row      = res_row_q;
	assign frame_last   = res_last_q;

	// While scanning, the running count has not passed the window size.
	a_cum_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (cum_q <= wsize_q))
		else $error("median scan count exceeds window size");

	// A result is only released after the histogram pipeline has emptied.
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> (!vld_s2 && !vld_s3))
		else $error("result emitted with histogram updates in flight");

	// A new result appears only out of the emit step.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> ($past(state_q) == BK_EMIT))
		else $error("result valid raised outside emit");
endmodule

@@ bench/running_histogram_median_filter_top_tb.sv @@
// Self-checking testbench for running_histogram_median_filter_top.
// Depends on rhmf_pkg and the RTL; it carries its own median predictor.
`timescale 1ns / 1ps
module running_histogram_median_filter_top_tb;
	import rhmf_pkg::*;

	// One window result as the block should report it.
	typedef struct packed {
		logic [7:0]  median;
		logic [9:0]  col;
		logic [11:0] row;
		logic        last;
	} median_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pixel_valid;
	logic        pixel_stall;
	logic [7:0]  pixel;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  median;
	logic [9:0]  out_col;
	logic [11:0] out_row;
	logic        frame_last;

	running_histogram_median_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.result_valid(result_valid), .result_stall(result_stall),
		.median(median), .out_col(out_col), .out_row(out_row),
		.frame_last(frame_last)
	);

	// Pixels waiting to be driven, and medians the block still owes us.
	logic [7:0]  pixel_q[$];
	median_res_t median_due[$];

	// Shadow of the block: registers, frame position and a copy of the rows.
	logic [10:0] img_w;
	logic [11:0] img_h;
	logic [2:0]  rad_c;
	logic [2:0]  rad_r;
	int          col_pos;
	int          row_pos;
	logic [7:0]  rows_seen[15][1024];

	// Idle percentages of the current phase on each side.
	int gap_pct;
	int stall_pct;

	int errors;
	int pixels_sent;
	int medians_checked;
	int phases_run;

	logic pix_taken;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Works out what one accepted pixel produces. A window result appears only
	// once the full window of the current frame has been written, so the copy
	// of the rows never needs to answer for an entry from an older frame.
	function automatic void predict_median(input logic [7:0] pix);
		int          w;
		int          h;
		int          hc;
		int          hr;
		int          wsize;
		int          cum;
		int          g;
		int          counts[256];
		median_res_t res;
		w = (img_w == 0) ? 1 : ((img_w > 1024) ? 1024 : int'(img_w));
		h = (img_h == 0) ? 1 : int'(img_h);
		hc = rad_c;
		hr = rad_r;
		wsize = (2 * hc + 1) * (2 * hr + 1);
		rows_seen[row_pos % 15][col_pos] = pix;
		if (col_pos >= 2 * hc && row_pos >= 2 * hr) begin
			foreach (counts[k]) counts[k] = 0;
			for (int i = row_pos - 2 * hr; i <= row_pos; i++)
				for (int j = col_pos - 2 * hc; j <= col_pos; j++)
					counts[rows_seen[i % 15][j]]++;
			cum = 0;
			g = 255;
			for (int k = 0; k < 256; k++) begin
				cum += counts[k];
				if (2 * cum > wsize) begin
					g = k;
					break;
				end
			end
			res.median = g[7:0];
			res.col = 10'(col_pos - hc);
			res.row = 12'(row_pos - hr);
			res.last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
			median_due.push_back(res);
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endfunction

	// Input side: a transaction is counted at the edge where valid is high and
	// stall is low; the driver looks at pix_taken on the following falling edge.
	// Output side: each accepted result is checked against the oldest median due.
	always @(posedge clk or negedge arst_n) begin
		median_res_t exp_res;
		if (!arst_n) begin
			pix_taken <= 1'b0;
		end else begin
			pix_taken <= pixel_valid && !pixel_stall;
			if (pixel_valid && !pixel_stall) begin
				predict_median(pixel);
				pixels_sent++;
			end
			if (result_valid && !result_stall) begin
				if (median_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result median %0d col %0d row %0d",
						median, out_col, out_row));
				end else begin
					exp_res = median_due.pop_front();
					medians_checked++;
					if (median !== exp_res.median)
						report_mismatch($sformatf("median %0d, expected %0d (col %0d row %0d)",
							median, exp_res.median, exp_res.col, exp_res.row));
					if (out_col !== exp_res.col)
						report_mismatch($sformatf("out_col %0d, expected %0d",
							out_col, exp_res.col));
					if (out_row !== exp_res.row)
						report_mismatch($sformatf("out_row %0d, expected %0d",
							out_row, exp_res.row));
					if (frame_last !== exp_res.last)
						report_mismatch($sformatf("frame_last %0b, expected %0b (col %0d row %0d)",
							frame_last, exp_res.last, exp_res.col, exp_res.row));
				end
			end
		end
	end

	// Pixel driver: a stalled pixel is held; otherwise the next one is offered
	// unless the phase asks for a gap in this cycle.
	always @(negedge clk) begin
		if (arst_n && (!pixel_valid || pix_taken)) begin
			if (pixel_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				pixel_valid <= 1'b1;
				pixel <= pixel_q.pop_front();
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall at random at the rate of the current phase.
	always @(negedge clk) begin
		if (arst_n)
			result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Writes one register through the APB port, reads it back and mirrors the
	// write in the shadow. Any write restarts the frame at column and row zero.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] mask;
		case (idx)
			REG_WIDTH:     mask = 32'h7FF;
			REG_HEIGHT:    mask = 32'hFFF;
			REG_HALF_COLS: mask = 32'h7;
			default:       mask = 32'h7;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (value & mask))
			report_mismatch($sformatf("register %s read back %0h, expected %0h",
				idx.name(), prdata, value & mask));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH:     img_w = value[10:0];
			REG_HEIGHT:    img_h = value[11:0];
			REG_HALF_COLS: rad_c = value[2:0];
			default:       rad_r = value[2:0];
		endcase
		col_pos = 0;
		row_pos = 0;
	endtask

	// Uniform grey, a narrow band, black/white only, or mostly white with some
	// uniform grey, so that ties and the extreme levels show up in windows often.
	function automatic logic [7:0] next_pixel(input int flavor);
		logic [7:0] p;
		case (flavor)
			0: p = 8'($urandom_range(0, 255));
			1: p = 8'($urandom_range(120, 124));
			2: p = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			default: p = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'd255;
		endcase
		return p;
	endfunction

	// Waits until the block has nothing outstanding: every pixel has been driven
	// and every median due has been checked. Border pixels owe no result, so the
	// back end is idle once the last due median has been taken.
	task automatic drain_block();
		do @(posedge clk);
		while (pixel_q.size() != 0 || pixel_valid || median_due.size() != 0);
		repeat (600) @(posedge clk);
	endtask

	// One configuration phase: program all four registers while idle, set the
	// idle pattern, push n pixels for the driver and wait for the block to drain.
	task automatic run_phase(input logic [31:0] w, input logic [31:0] h,
			input logic [31:0] hc, input logic [31:0] hr, input int n, input int flavor);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_HALF_COLS, hc);
		write_reg(REG_HALF_ROWS, hr);
		case (phases_run % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 58; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 58; end
			default: begin gap_pct = 25; stall_pct = 25; end
		endcase
		for (int i = 0; i < n; i++)
			pixel_q.push_back(next_pixel(flavor));
		phases_run++;
		drain_block();
	endtask

	initial begin
		logic [7:0] directed[$];
		int         total;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_stall = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		errors = 0;
		pixels_sent = 0;
		medians_checked = 0;
		phases_run = 0;
		img_w = RST_WIDTH;
		img_h = RST_HEIGHT;
		rad_c = RST_HALF;
		rad_r = RST_HALF;
		col_pos = 0;
		row_pos = 0;
		foreach (rows_seen[i, j]) rows_seen[i][j] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: an 8 by 3 image with a 3 by 3 window, so the last row
		// ends the frame. Pixel values cover the extremes and every bit.
		directed = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254, 8'h55, 8'hAA,
			8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd7, 8'd200,
			8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd64, 8'd32};
		write_reg(REG_WIDTH, 8);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_HALF_COLS, 1);
		write_reg(REG_HALF_ROWS, 1);
		foreach (directed[i]) pixel_q.push_back(directed[i]);
		phases_run++;
		drain_block();

		// Zero width and height act as one pixel per frame: every pixel is its
		// own window and ends the frame.
		run_phase(0, 0, 0, 0, 20, 0);
		// Width beyond the limit saturates; only part of the first row is sent
		// so the phase ends in mid-frame.
		run_phase(2047, 4095, 0, 0, 40, 0);
		// Largest window on a 16 by 16 image, one pixel wider and taller than it.
		run_phase(16, 16, 7, 7, 256, 0);
		// Window wider and taller than the image: no result at all.
		run_phase(5, 4, 3, 3, 40, 0);
		// Widest legal row, one row high, with a horizontal-only window.
		run_phase(1024, 1, 7, 0, 40, 2);
		// Two frames back to back to check the wrap to a new frame.
		run_phase(6, 4, 1, 1, 48, 1);

		// Random part: small images, small radii, one or two frames each, and
		// now and then a frame cut short by the next configuration write.
		total = pixels_sent;
		while (total < 1450) begin
			int w;
			int h;
			int n;
			w = $urandom_range(1, 20);
			h = $urandom_range(1, 10);
			n = w * h * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, n);
			run_phase(w, h, $urandom_range(0, 3), $urandom_range(0, 3), n,
				$urandom_range(0, 3));
			total = pixels_sent;
		end

		$display("Ran %0d configuration phases with %0d pixel transactions.",
			phases_run, pixels_sent);
		$display("Checked %0d median transactions; %0d mismatches.",
			medians_checked, errors);
		if (errors == 0)
			$display("running_histogram_median_filter_top_tb passed");
		else
			$display("running_histogram_median_filter_top_tb failed");
		$finish;
	end

	// Watchdog: the slowest correct run is well below this.
	initial begin
		#60ms;
		$display("Timeout with %0d medians still due.", median_due.size());
		$display("running_histogram_median_filter_top_tb failed");
		$finish;
	end

endmodule
